FILE: rtl/tlb_page_table_fifo_mmu_core_macros.svh
// assertion macros shared by the mmu core rtl
`ifndef TLB_PAGE_TABLE_FIFO_MMU_CORE_MACROS_SVH
`define TLB_PAGE_TABLE_FIFO_MMU_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define TPFM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mmu core assertion failed");
`define TPFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mmu core assertion failed");
`else
`define TPFM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TPFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/tpfm_pkg.sv
// shared types and constants of the mmu core
package tpfm_pkg;

    localparam int ADDR_W      = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int FRAME_OUT_W = 3;
    localparam int OUTCOME_W   = 2;
    localparam int EVPAGE_W    = 5;

    localparam logic [OUTCOME_W-1:0] OUTCOME_TLB_HIT = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_PT_HIT  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FAULT   = 2'd2;

    localparam logic CMD_WRITE = 1'b1;

    // result transaction, last field in the lowest bits
    typedef struct packed {
        logic                   repeat_write;
        logic                   write_back;
        logic [EVPAGE_W-1:0]    evicted_page;
        logic                   evicted_valid;
        logic [OUTCOME_W-1:0]   outcome;
        logic [FRAME_OUT_W-1:0] frame_number;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

FILE: rtl/tpfm_ram.sv
// single write port, single read port memory with registered read data
module tpfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/tpfm_tlb.sv
// translation buffer: parallel lookup and fifo or retarget install
module tpfm_tlb #(
    parameter int FRAMES = 8,
    parameter int PW     = 5,
    parameter int FW     = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [PW-1:0] lookup_page,
    output logic          hit,
    output logic [FW-1:0] hit_frame,
    input  logic          install_en,
    input  logic [FW-1:0] install_frame,
    input  logic [PW-1:0] install_page
);

    logic          in_use_reg [FRAMES];
    logic [PW-1:0] page_reg   [FRAMES];
    logic [FW-1:0] frame_reg  [FRAMES];
    logic [FW-1:0] ptr_reg;

    logic          match_found;
    logic [FW-1:0] match_idx;

    // lowest in-use entry wins
    always_comb begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (in_use_reg[i] && page_reg[i] == lookup_page) begin
                hit       = 1'b1;
                hit_frame = frame_reg[i];
            end
        end
    end

    always_comb begin
        match_found = 1'b0;
        match_idx   = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (in_use_reg[i] && frame_reg[i] == install_frame) begin
                match_found = 1'b1;
                match_idx   = FW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                in_use_reg[i] <= 1'b0;
            end
        end else if (install_en) begin
            if (match_found) begin
                page_reg[match_idx] <= install_page;
            end else begin
                page_reg[ptr_reg]   <= install_page;
                frame_reg[ptr_reg]  <= install_frame;
                in_use_reg[ptr_reg] <= 1'b1;
                if (ptr_reg == FW'(FRAMES - 1)) begin
                    ptr_reg <= '0;
                end else begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/tlb_page_table_fifo_mmu_core.sv
// top level of the mmu core: control sequencer, page table and frame owner memories
//
// address translation with a translation buffer, a page table and fifo page
// replacement. each input transaction carries a read or write access; each one
// gives exactly one result transaction. after reset the core sweeps every
// page table entry clean before it takes the first access. an access then
// passes look and out on a hit in the translation buffer or the page table,
// look, install and out on a fault into a frame never used, and look, evict,
// install and out on a fault that ejects a resident page, as the page table
// memory has a single write port: such a fault reads the ejected page's
// entry, then clears it and installs the new page in two separate writes. the
// result sits in an output register, so the next access is taken while it waits.
`include "tlb_page_table_fifo_mmu_core_macros.svh"

module tlb_page_table_fifo_mmu_core
    import tpfm_pkg::*;
#(
    parameter int FRAMES        = 8,
    parameter int VIRTUAL_PAGES = 32,
    parameter int OFFSET_BITS   = 11
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // access in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] access address
    input  logic [0:0]             s_axis_tuser,   // [0] command
    // result out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [2:0] frame_number, [4:3] outcome, [5] evicted_valid, [10:6] evicted_page,
    // [11] write_back, [12] repeat_write, [15:13] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int PW    = $clog2(VIRTUAL_PAGES);
    localparam int FW    = $clog2(FRAMES);
    localparam int PTE_W = FW + 2;   // {present, dirty, frame}

    // sequencer states
    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_LOOK    = 3'd2;
    localparam logic [2:0] S_EVICT   = 3'd3;
    localparam logic [2:0] S_INSTALL = 3'd4;
    localparam logic [2:0] S_OUT     = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [PW-1:0]     clr_cnt_reg;

    // latched access
    logic              cmd_reg;
    logic [PW-1:0]     page_reg;
    logic              in_range_reg;

    // fifo frame slot; wrapped means every frame has an owner
    logic [FW-1:0]     fp_reg;
    logic              wrapped_reg;
    logic [PW-1:0]     old_page_reg;

    result_t           res_reg, res_next;
    logic              m_valid_reg;
    result_t           m_data_reg;

    // page of the incoming transaction
    logic [ADDR_W-1:0] s_page_full;
    logic              accept;

    // page table port
    logic              pt_we;
    logic [PW-1:0]     pt_waddr;
    logic [PTE_W-1:0]  pt_wdata;
    logic [PW-1:0]     pt_raddr;
    logic [PTE_W-1:0]  pt_q;
    logic              pt_present;
    logic              pt_dirty;
    logic [FW-1:0]     pt_frame;

    // frame owner port
    logic              own_we;
    logic [PW-1:0]     own_q;

    // translation buffer
    logic              tlb_hit;
    logic [FW-1:0]     tlb_frame;
    logic              tlb_install;

    logic              fault;
    logic              out_free;

    assign s_page_full = s_axis_tdata >> OFFSET_BITS;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign pt_present = pt_q[FW+1];
    assign pt_dirty   = pt_q[FW];
    assign pt_frame   = pt_q[FW-1:0];

    assign fault    = in_range_reg && !tlb_hit && !pt_present;
    assign out_free = !m_valid_reg || m_axis_tready;

    // page table read: the access's page when idle, otherwise the ejected page
    assign pt_raddr = (state_reg == S_IDLE) ? s_page_full[PW-1:0] : own_q;

    tpfm_ram #(
        .WIDTH (PTE_W),
        .DEPTH (VIRTUAL_PAGES)
    ) u_page_table (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_q)
    );

    // frame owner page; its valid mark follows from the fifo fill state
    assign own_we = (state_reg == S_LOOK) && fault;

    tpfm_ram #(
        .WIDTH (PW),
        .DEPTH (FRAMES)
    ) u_frame_owner (
        .aclk  (aclk),
        .we    (own_we),
        .waddr (fp_reg),
        .wdata (page_reg),
        .raddr (fp_reg),
        .rdata (own_q)
    );

    assign tlb_install = (state_reg == S_INSTALL);

    tpfm_tlb #(
        .FRAMES (FRAMES),
        .PW     (PW),
        .FW     (FW)
    ) u_tlb (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .lookup_page   (page_reg),
        .hit           (tlb_hit),
        .hit_frame     (tlb_frame),
        .install_en    (tlb_install),
        .install_frame (fp_reg),
        .install_page  (page_reg)
    );

    // page table write port
    always_comb begin
        pt_we    = 1'b0;
        pt_waddr = page_reg;
        pt_wdata = '0;
        case (state_reg)
            S_CLEAR: begin
                pt_we    = 1'b1;
                pt_waddr = clr_cnt_reg;
            end
            S_LOOK: begin
                // a write on a hit marks the page dirty
                if (in_range_reg && (tlb_hit || pt_present) && cmd_reg == CMD_WRITE) begin
                    pt_we    = 1'b1;
                    pt_wdata = {pt_present, 1'b1, pt_frame};
                end
            end
            S_EVICT: begin
                pt_we    = 1'b1;
                pt_waddr = old_page_reg;
            end
            S_INSTALL: begin
                pt_we    = 1'b1;
                pt_wdata = {1'b1, cmd_reg == CMD_WRITE, fp_reg};
            end
            default: begin
                pt_we = 1'b0;
            end
        endcase
    end

    // sequencer and result build
    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == PW'(VIRTUAL_PAGES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                res_next = '0;
                if (!in_range_reg) begin
                    // page beyond the table: nothing changes
                    res_next.outcome = OUTCOME_PT_HIT;
                    state_next       = S_OUT;
                end else if (tlb_hit) begin
                    res_next.frame_number = FRAME_OUT_W'(tlb_frame);
                    res_next.outcome      = OUTCOME_TLB_HIT;
                    res_next.repeat_write = (cmd_reg == CMD_WRITE) && pt_dirty;
                    state_next            = S_OUT;
                end else if (pt_present) begin
                    res_next.frame_number = FRAME_OUT_W'(pt_frame);
                    res_next.outcome      = OUTCOME_PT_HIT;
                    res_next.repeat_write = (cmd_reg == CMD_WRITE) && pt_dirty;
                    state_next            = S_OUT;
                end else begin
                    res_next.frame_number  = FRAME_OUT_W'(fp_reg);
                    res_next.outcome       = OUTCOME_FAULT;
                    res_next.evicted_valid = wrapped_reg;
                    if (wrapped_reg) begin
                        res_next.evicted_page = EVPAGE_W'(own_q);
                        state_next            = S_EVICT;
                    end else begin
                        state_next = S_INSTALL;
                    end
                end
            end
            S_EVICT: begin
                // pt_q now holds the ejected page's entry
                res_next.write_back = pt_dirty;
                state_next          = S_INSTALL;
            end
            S_INSTALL: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            fp_reg      <= '0;
            wrapped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == S_INSTALL) begin
                if (fp_reg == FW'(FRAMES - 1)) begin
                    fp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    fp_reg <= fp_reg + 1'b1;
                end
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (accept) begin
            cmd_reg      <= s_axis_tuser[0];
            page_reg     <= s_page_full[PW-1:0];
            in_range_reg <= (s_page_full < ADDR_W'(VIRTUAL_PAGES));
        end
        if (state_reg == S_LOOK) begin
            old_page_reg <= own_q;
        end
        if (state_reg == S_OUT && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), m_data_reg};

    `TPFM_ASSERT_NEXT(a_accept_to_look, aclk, aresetn, accept, state_reg == S_LOOK)
    `TPFM_ASSERT_NEXT(a_evict_on_full_fault, aclk, aresetn, (state_reg == S_LOOK) && fault && wrapped_reg, state_reg == S_EVICT)
    `TPFM_ASSERT_IMPL(a_wb_needs_evict, aclk, aresetn, m_axis_tvalid && !m_data_reg.evicted_valid, !m_data_reg.write_back)
    `TPFM_ASSERT_IMPL(a_no_repeat_on_fault, aclk, aresetn, m_axis_tvalid && (m_data_reg.outcome == OUTCOME_FAULT), !m_data_reg.repeat_write)

endmodule

FILE: bench/tlb_page_table_fifo_mmu_core_tb.sv
// self-checking testbench of the mmu core with a tlb, a page table and fifo replacement
`timescale 1ns / 1ps

module tlb_page_table_fifo_mmu_core_tb;
    import tpfm_pkg::*;

    // geometry of the default build
    localparam int FRAME_COUNT  = 8;
    localparam int PAGE_COUNT   = 32;
    localparam int PAGE_LSB     = 11;

    localparam logic CMD_READ   = 1'b0;

    // random part and its shaping
    localparam int RANDOM_ACCESSES = 1700;
    localparam int WINDOW_SPAN     = 10;   // pages in the hot working set
    localparam int WINDOW_STEP     = 150;  // accesses before the hot set moves
    localparam int CALM_FIRST      = 600;  // no idling on either side in this range
    localparam int CALM_LAST       = 900;
    localparam int HOLD_AT_RESULT  = 1200; // receiver holds off once here
    localparam int HOLD_CYCLES     = 400;
    localparam int IDLE_PERCENT    = 6;
    localparam int QUIET_LIMIT     = 4000; // cycles with no transaction at all
    localparam int DRAIN_CYCLES    = 12;

    // tracks the translation state and holds the results still owed by the core
    class mmu_scoreboard;
        result_t     expected_q[$];
        int unsigned failures;
        int unsigned mismatches;

        // page table: present, dirty and frame per virtual page
        bit          pt_present [PAGE_COUNT];
        bit          pt_dirty   [PAGE_COUNT];
        bit [2:0]    pt_frame   [PAGE_COUNT];
        // owner of each physical frame
        bit          owner_valid [FRAME_COUNT];
        bit [4:0]    owner_page  [FRAME_COUNT];
        bit [2:0]    victim_slot;
        // translation buffer
        bit          tlb_used  [FRAME_COUNT];
        bit [4:0]    tlb_page  [FRAME_COUNT];
        bit [2:0]    tlb_frame [FRAME_COUNT];
        bit [2:0]    tlb_slot;

        function new();
            failures    = 0;
            mismatches  = 0;
            victim_slot = '0;
            tlb_slot    = '0;
            foreach (pt_present[p]) begin
                pt_present[p] = 1'b0;
                pt_dirty[p]   = 1'b0;
                pt_frame[p]   = '0;
            end
            foreach (owner_valid[f]) begin
                owner_valid[f] = 1'b0;
                owner_page[f]  = '0;
                tlb_used[f]    = 1'b0;
                tlb_page[f]    = '0;
                tlb_frame[f]   = '0;
            end
        endfunction

        // retarget the buffer entry that holds the frame, else fill the fifo slot
        function void map_frame(bit [2:0] frame, bit [4:0] page);
            bit found;
            found = 1'b0;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                if (!found && tlb_used[i] && tlb_frame[i] == frame) begin
                    tlb_page[i] = page;
                    found = 1'b1;
                end
            end
            if (!found) begin
                tlb_used[tlb_slot]  = 1'b1;
                tlb_page[tlb_slot]  = page;
                tlb_frame[tlb_slot] = frame;
                tlb_slot++;
            end
        endfunction

        function result_t translate(logic cmd, logic [ADDR_W-1:0] addr);
            result_t  r;
            bit [4:0] page;
            bit [4:0] old_page;
            bit       is_write;
            bit       hit;
            r        = '0;
            page     = addr[ADDR_W-1:PAGE_LSB];
            is_write = (cmd == CMD_WRITE);
            hit      = 1'b0;
            // lowest matching entry wins
            for (int i = 0; i < FRAME_COUNT; i++) begin
                if (!hit && tlb_used[i] && tlb_page[i] == page) begin
                    hit            = 1'b1;
                    r.frame_number = tlb_frame[i];
                end
            end
            if (hit || pt_present[page]) begin
                r.outcome = hit ? OUTCOME_TLB_HIT : OUTCOME_PT_HIT;
                if (!hit)
                    r.frame_number = pt_frame[page];
                if (is_write) begin
                    r.repeat_write = pt_dirty[page];
                    pt_dirty[page] = 1'b1;
                end
            end else begin
                r.outcome      = OUTCOME_FAULT;
                r.frame_number = victim_slot;
                if (owner_valid[victim_slot]) begin
                    old_page             = owner_page[victim_slot];
                    r.evicted_valid      = 1'b1;
                    r.evicted_page       = old_page;
                    r.write_back         = pt_dirty[old_page];
                    pt_dirty[old_page]   = 1'b0;
                    pt_present[old_page] = 1'b0;
                    pt_frame[old_page]   = '0;
                end
                owner_valid[victim_slot] = 1'b1;
                owner_page[victim_slot]  = page;
                pt_present[page]         = 1'b1;
                pt_frame[page]           = victim_slot;
                map_frame(victim_slot, page);
                victim_slot++;
                if (is_write)
                    pt_dirty[page] = 1'b1;
            end
            return r;
        endfunction

        function void note_access(logic cmd, logic [ADDR_W-1:0] addr);
            expected_q.push_back(translate(cmd, addr));
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[RESULT_W-1:0]);
            if (expected_q.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: tdata %h", data);
                return;
            end
            want = expected_q.pop_front();
            if (got.frame_number  !== want.frame_number  ||
                got.outcome       !== want.outcome       ||
                got.evicted_valid !== want.evicted_valid ||
                got.evicted_page  !== want.evicted_page  ||
                got.write_back    !== want.write_back    ||
                got.repeat_write  !== want.repeat_write) begin
                failures++;
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch (expected/actual): frame %0d/%0d outcome %0d/%0d",
                             want.frame_number, got.frame_number,
                             want.outcome, got.outcome);
                    $display("  evicted %0d/%0d page %0d/%0d wb %0d/%0d repeat %0d/%0d",
                             want.evicted_valid, got.evicted_valid,
                             want.evicted_page, got.evicted_page,
                             want.write_back, got.write_back,
                             want.repeat_write, got.repeat_write);
                end
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    mmu_scoreboard board;
    int unsigned   accesses_sent;
    int unsigned   results_seen;
    int unsigned   quiet_cycles;

    tlb_page_table_fifo_mmu_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // offer one access and wait until the core takes it; random idle cycles before it,
    // except in the calm stretch
    task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr);
        bit calm;
        calm = (accesses_sent >= CALM_FIRST && accesses_sent < CALM_LAST);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        s_axis_tuser  <= cmd;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        // transaction taken at this edge
        board.note_access(cmd, addr);
        accesses_sent++;
    endtask

    task automatic send_page(input logic cmd, input int page);
        send_access(cmd, {page[4:0], PAGE_LSB'($urandom)});
    endtask

    // directed part: fill every frame, hits with and without a dirty page,
    // evictions of clean and dirty pages, a write on fault, extreme addresses
    task automatic run_directed();
        send_access(CMD_READ,  16'h0000);        // fault into an empty frame
        send_access(CMD_WRITE, 16'h07ff);        // buffer hit, first write
        send_access(CMD_WRITE, 16'h0400);        // buffer hit, repeat write
        send_access(CMD_READ,  16'hffff);        // top page, fault
        for (int p = 1; p <= 6; p++)
            send_page(CMD_WRITE, p);             // fill the remaining frames dirty
        send_access(CMD_READ,  16'h0800);        // read hit on a dirty page
        send_page(CMD_READ, 7);                  // eject dirty page 0
        send_page(CMD_READ, 0);                  // eject clean page 31
        send_page(CMD_WRITE, 8);                 // write on fault ejecting dirty page 1
        send_page(CMD_WRITE, 8);                 // repeat write right after the fault
        send_access(CMD_READ,  16'hf800);        // page 31 back in
        send_access(CMD_WRITE, 16'haaaa);
        send_access(CMD_WRITE, 16'h5555);
        send_access(CMD_READ,  16'haaaa);
        send_access(CMD_READ,  16'h5555);
        send_access(CMD_WRITE, 16'h5555);
        send_page(CMD_READ, 7);
    endtask

    // random part: mostly a small moving hot set so that hits and repeat writes
    // are frequent, the rest anywhere in the address space
    task automatic run_random();
        int base;
        int page;
        base = 0;
        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            if (n % WINDOW_STEP == 0)
                base = $urandom_range(PAGE_COUNT - 1);
            if ($urandom_range(99) < 75)
                page = (base + $urandom_range(WINDOW_SPAN - 1)) % PAGE_COUNT;
            else
                page = $urandom_range(PAGE_COUNT - 1);
            send_page(logic'($urandom_range(1)), page);
        end
    endtask

    // result side: check every accepted transaction, stall at random, and hold off
    // once for a long stretch so the core backs up and stalls its input
    initial begin : result_side
        int  hold_left;
        bit  held;
        bit  calm;
        hold_left = 0;
        held      = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                board.check_result(m_axis_tdata);
                results_seen++;
            end
            if (!held && results_seen == HOLD_AT_RESULT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            calm = (results_seen >= CALM_FIRST && results_seen < CALM_LAST);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tlb_page_table_fifo_mmu_core_tb: FAIL");
            $finish;
        end
    end

    // main sequence: reset once, directed part, random part, drain, verdict
    initial begin
        board         = new();
        accesses_sent = 0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // the core clears its page table first; send_access just waits for tready
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;

        while (board.expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.failures == 0 && board.expected_q.size() == 0)
            $display("tlb_page_table_fifo_mmu_core_tb: PASS");
        else
            $display("tlb_page_table_fifo_mmu_core_tb: FAIL");
        $finish;
    end

endmodule
